// ===== hw/rtl/bcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared widths, register indexes and sign/zero extension helpers for the
// barometric compensation smoother.
// ----------------------------------------------------------------------------
package bcs_pkg;

	// exact polynomial sum over 2^112 plus headroom for every term, down to
	// eight temperature fraction bits
	localparam int ACC_W = 160;
	// multiplier operand: 24-bit reading plus sign
	localparam int MP_W = 25;
	localparam int CNT_W = $clog2(MP_W);

	localparam logic [21:0] OUT_MAX = 22'h3FFFFF;
	localparam logic [16:0] ALPHA_ONE = 17'd65536;

	localparam logic [2:0] REG_TEMP_CALIB = 3'd0;
	localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
	localparam logic [2:0] REG_PRESS_MID  = 3'd2;
	localparam logic [2:0] REG_PRESS_HIGH = 3'd3;
	localparam logic [2:0] REG_ALPHA      = 3'd4;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [MP_W-1:0] mplier_t;

	function automatic acc_t sx8(input logic [7:0] v);
		return {{(ACC_W-8){v[7]}}, v};
	endfunction

	function automatic acc_t sx16(input logic [15:0] v);
		return {{(ACC_W-16){v[15]}}, v};
	endfunction

	function automatic acc_t zx16(input logic [15:0] v);
		return {{(ACC_W-16){1'b0}}, v};
	endfunction

	function automatic acc_t zx22(input logic [21:0] v);
		return {{(ACC_W-22){1'b0}}, v};
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bcs_serial_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcs_serial_mac
// Bit-serial multiply-add: result = mcand * mplier + addend, one multiplier
// bit per cycle. The multiplier is two's complement; its top bit weighs
// negative.
// ----------------------------------------------------------------------------
module bcs_serial_mac (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire bcs_pkg::acc_t    mcand,
	input  wire bcs_pkg::mplier_t mplier,
	input  wire bcs_pkg::acc_t    addend,
	output logic                  done,
	output bcs_pkg::acc_t         result
);
	import bcs_pkg::*;

	acc_t             mc_q;
	acc_t             pr_q;
	acc_t             pr_nxt;
	logic [MP_W-1:0]  mp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             last;

	assign last = (cnt_q == CNT_W'(MP_W - 1));

	always_comb begin
		pr_nxt = pr_q;
		if (mp_q[0]) begin
			// sign bit of the multiplier subtracts
			pr_nxt = last ? (pr_q - mc_q) : (pr_q + mc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q <= mcand;
			mp_q <= mplier;
			pr_q <= addend;
		end else if (busy_q) begin
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
			pr_q <= pr_nxt;
		end
	end

	assign done   = done_q;
	assign result = pr_q;

endmodule
`default_nettype wire

// ===== hw/rtl/barometric_compensation_smoother_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// barometric_compensation_smoother_unit
// Temperature and pressure compensation from raw calibration bytes, with an
// exponential smoother on the valid pressure results.
// ----------------------------------------------------------------------------
// The whole computation of one item runs as 14 multiply-add passes on one
// bit-serial MAC, each pass a load state and then the serial multiply.
// Two passes form the temperature quadratic, ten evaluate the pressure
// polynomial in Horner form (exact, over a 2^112 denominator) and two form
// the smoother blend. A new item is taken once the previous one has reached
// the output register, so a result may wait there while the next item is
// computed.
module barometric_compensation_smoother_unit #(
	parameter int TEMP_FRAC_BITS  = 16,
	parameter int PRESS_FRAC_BITS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [23:0] raw_pressure,
	input  wire logic [23:0] raw_temperature,
	input  wire logic        restart_filter,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [23:0] temperature_q16,
	output logic [21:0]      pressure_sixteenths,
	output logic [21:0]      smoothed_pressure,
	output logic             sample_valid,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);
	import bcs_pkg::*;

	localparam int F = TEMP_FRAC_BITS;

	localparam acc_t TQ_MAX  = ACC_W'(8388607);
	localparam acc_t TQ_MIN  = ACC_W'(-8388608);
	localparam acc_t P_MAX   = ACC_W'(4194303);
	localparam acc_t OFS_P12 = ACC_W'(16384);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		STEP_TA, STEP_TB,
		STEP_P2A, STEP_P2B,
		STEP_P1A, STEP_P1B, STEP_P1C, STEP_P1D,
		STEP_P0A, STEP_P0B, STEP_P0C, STEP_P0D,
		STEP_SA, STEP_SB
	} step_t;

	state_t state_q;
	step_t  step_q;

	logic [39:0] temp_calib_q;
	logic [47:0] press_low_q;
	logic [47:0] press_mid_q;
	logic [31:0] press_high_q;
	logic [16:0] alpha_q;

	logic [23:0] rp_q;
	logic [23:0] rt_q;
	logic        restart_q;
	logic signed [23:0] tq_q;
	logic [21:0] press_q;
	logic        valid_q;
	acc_t        r_q;
	acc_t        h_q;
	logic [21:0] smoothed_q;
	logic        seeded_q;

	acc_t    mcand;
	mplier_t mplier;
	acc_t    addend;
	logic    mac_start;
	logic    mac_done;
	acc_t    mac_res;
	logic    dest_h;

	mplier_t d;
	mplier_t t_op;
	mplier_t p_op;
	logic [16:0] alpha_c;
	logic [17:0] alpha_inv;

	acc_t        tsh;
	logic signed [23:0] tq_nxt;
	acc_t        qsh;
	logic [21:0] press_nxt;
	logic        valid_nxt;
	logic [21:0] smooth_nxt;
	logic        accept;
	logic        commit;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign commit   = (state_q == ST_OUT) && (!out_valid || out_ready);

	// d = raw_temperature - t1 * 256, always fits 25 bits signed
	assign d = $signed({1'b0, rt_q}) - $signed({1'b0, temp_calib_q[15:0], 8'h00});
	assign t_op = {tq_q[23], tq_q};
	assign p_op = {1'b0, rp_q};
	assign alpha_c = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign alpha_inv = 18'd65536 - {1'b0, alpha_c};

	always_comb begin
		mcand  = '0;
		mplier = '0;
		addend = '0;
		dest_h = 1'b0;
		unique case (step_q)
			STEP_TA: begin
				mcand  = sx8(temp_calib_q[39:32]);
				mplier = d;
				addend = zx16(temp_calib_q[31:16]) <<< 18;
			end
			STEP_TB: begin
				mcand  = r_q;
				mplier = d;
			end
			STEP_P2A: begin
				mcand  = sx8(press_high_q[23:16]);
				mplier = t_op;
				addend = sx16(press_high_q[15:0]) <<< F;
			end
			STEP_P2B: begin
				mcand  = sx8(press_high_q[31:24]) <<< 47;
				mplier = p_op;
				addend = r_q <<< (64 - F);
				dest_h = 1'b1;
			end
			STEP_P1A: begin
				mcand  = sx8(press_low_q[47:40]);
				mplier = t_op;
				addend = sx8(press_low_q[39:32]) <<< (5 + F);
			end
			STEP_P1B: begin
				mcand  = r_q;
				mplier = t_op;
				addend = (sx16(press_low_q[31:16]) - OFS_P12) <<< (8 + 2 * F);
			end
			STEP_P1C: begin
				mcand  = r_q;
				mplier = t_op;
				addend = (sx16(press_low_q[15:0]) - OFS_P12) <<< (17 + 3 * F);
			end
			STEP_P1D: begin
				mcand  = h_q;
				mplier = p_op;
				addend = r_q <<< (75 - 3 * F);
				dest_h = 1'b1;
			end
			STEP_P0A: begin
				mcand  = sx8(press_mid_q[47:40]);
				mplier = t_op;
				addend = sx8(press_mid_q[39:32]) <<< (7 + F);
			end
			STEP_P0B: begin
				mcand  = r_q;
				mplier = t_op;
				addend = zx16(press_mid_q[31:16]) <<< (9 + 2 * F);
			end
			STEP_P0C: begin
				mcand  = r_q;
				mplier = t_op;
				addend = zx16(press_mid_q[15:0]) <<< (18 + 3 * F);
			end
			STEP_P0D: begin
				mcand  = h_q;
				mplier = p_op;
				addend = r_q <<< (97 - 3 * F);
				dest_h = 1'b1;
			end
			STEP_SA: begin
				mcand  = zx22(smoothed_q);
				mplier = {7'b0, alpha_inv};
			end
			STEP_SB: begin
				mcand  = zx22(press_q);
				mplier = {8'b0, alpha_c};
				addend = r_q;
			end
			default: begin
				mcand  = '0;
			end
		endcase
	end

	assign mac_start = (state_q == ST_LOAD);

	bcs_serial_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.mcand  (mcand),
		.mplier (mplier),
		.addend (addend),
		.done   (mac_done),
		.result (mac_res)
	);

	// floor and saturate the temperature
	always_comb begin
		tsh = mac_res >>> (48 - F);
		if (tsh > TQ_MAX) begin
			tq_nxt = 24'sh7FFFFF;
		end else if (tsh < TQ_MIN) begin
			tq_nxt = -24'sh800000;
		end else begin
			tq_nxt = tsh[23:0];
		end
	end

	// floor to the output fraction and clamp; the sign and zero test is exact
	always_comb begin
		qsh = mac_res >>> (112 - PRESS_FRAC_BITS);
		valid_nxt = !mac_res[ACC_W-1] && (mac_res != '0);
		if (mac_res[ACC_W-1]) begin
			press_nxt = '0;
		end else if (qsh > P_MAX) begin
			press_nxt = OUT_MAX;
		end else begin
			press_nxt = qsh[21:0];
		end
	end

	always_comb begin
		smooth_nxt = smoothed_q;
		if (valid_q) begin
			smooth_nxt = (!seeded_q || restart_q) ? press_q : r_q[37:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= STEP_TA;
			out_valid  <= 1'b0;
			smoothed_q <= '0;
			seeded_q   <= 1'b0;
		end else begin
			if (out_valid && out_ready && !commit) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q  <= STEP_TA;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mac_done) begin
						if (step_q == STEP_SB) begin
							state_q <= ST_OUT;
						end else begin
							step_q  <= step_t'(step_q + 4'd1);
							state_q <= ST_LOAD;
						end
					end
				end
				ST_OUT: begin
					if (commit) begin
						out_valid <= 1'b1;
						smoothed_q <= smooth_nxt;
						if (valid_q) begin
							seeded_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q  <= '0;
			press_mid_q  <= '0;
			press_high_q <= '0;
			alpha_q      <= ALPHA_ONE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_TEMP_CALIB: temp_calib_q <= cfg_data[39:0];
				REG_PRESS_LOW:  press_low_q  <= cfg_data;
				REG_PRESS_MID:  press_mid_q  <= cfg_data;
				REG_PRESS_HIGH: press_high_q <= cfg_data[31:0];
				REG_ALPHA:      alpha_q      <= cfg_data[16:0];
				default: begin
					alpha_q <= alpha_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rp_q      <= raw_pressure;
			rt_q      <= raw_temperature;
			restart_q <= restart_filter;
		end
		if (state_q == ST_MUL && mac_done) begin
			if (dest_h) begin
				h_q <= mac_res;
			end else begin
				r_q <= mac_res;
			end
			if (step_q == STEP_TB) begin
				tq_q <= tq_nxt;
			end
			if (step_q == STEP_P0D) begin
				press_q <= press_nxt;
				valid_q <= valid_nxt;
			end
		end
		if (commit) begin
			temperature_q16     <= tq_q;
			pressure_sixteenths <= press_q;
			smoothed_pressure   <= smooth_nxt;
			sample_valid        <= valid_q;
		end
	end

endmodule
`default_nettype wire

// ===== test/barometric_compensation_smoother_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_compensation_smoother_unit_tb
// Drives raw pressure/temperature pairs through the compensation smoother
// under several calibration sets and alpha settings. An exact wide-integer
// predictor supplies the expected results, but the first four table rows carry
// a fixed zero result. Both handshakes idle at random in some phases.
// ----------------------------------------------------------------------------
module barometric_compensation_smoother_unit_tb;
	import bcs_pkg::*;

	localparam int TF = 16;
	localparam int PF = 4;
	localparam int SUM_SH = 112;
	localparam int DRAIN_CYCLES = 500;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int RAND_PER_PHASE = 155;

	typedef enum logic [2:0] {
		CFG_TEMP = REG_TEMP_CALIB,
		CFG_PLOW = REG_PRESS_LOW,
		CFG_PMID = REG_PRESS_MID,
		CFG_PHIGH = REG_PRESS_HIGH,
		CFG_ALPHA = REG_ALPHA,
		CFG_SPARE = 3'd5
	} cfg_reg_t;

	typedef struct {
		logic signed [23:0] temp;
		logic [21:0] press;
		logic [21:0] smooth;
		logic valid;
	} comp_result_t;

	typedef struct {
		logic [23:0] rp;
		logic [23:0] rt;
		logic rs;
		logic typed;
		comp_result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [23:0] raw_pressure = '0;
	logic [23:0] raw_temperature = '0;
	logic restart_filter = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [23:0] temperature_q16;
	logic [21:0] pressure_sixteenths;
	logic [21:0] smoothed_pressure;
	logic sample_valid;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;

	barometric_compensation_smoother_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
		.restart_filter(restart_filter),
		.out_valid(out_valid), .out_ready(out_ready),
		.temperature_q16(temperature_q16), .pressure_sixteenths(pressure_sixteenths),
		.smoothed_pressure(smoothed_pressure), .sample_valid(sample_valid),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// bench copy of the registers and smoother state
	logic [39:0] temp_reg = '0;
	logic [47:0] plow_reg = '0;
	logic [47:0] pmid_reg = '0;
	logic [31:0] phigh_reg = '0;
	logic [16:0] alpha_reg = ALPHA_ONE;
	logic [21:0] smooth_state = '0;
	logic seeded = 1'b0;

	comp_result_t pending_q[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int quiet_cycles = 0;
	int n_items = 0;
	int n_results = 0;
	int n_valid = 0;

	function automatic logic signed [255:0] poly_term(input longint c, input int np,
		input int nt, input longint p, input longint t, input int sh);
		logic signed [255:0] v;
		v = c;
		for (int i = 0; i < np; i++) v = v * p;
		for (int i = 0; i < nt; i++) v = v * t;
		return v <<< sh;
	endfunction

	// exact compensation plus smoother update; advances the bench state
	function automatic comp_result_t compensate(input logic [23:0] rp_in,
		input logic [23:0] rt_in, input logic rs);
		longint p, t1, t2, t3, d, num, tq;
		logic signed [255:0] acc, q;
		logic [63:0] press, a, s;
		comp_result_t r;
		p = rp_in;
		t1 = temp_reg[15:0];
		t2 = temp_reg[31:16];
		t3 = $signed(temp_reg[39:32]);
		d = longint'(rt_in) - t1 * 256;
		num = d * t2 * 262144 + d * d * t3;
		tq = num >>> (48 - TF);
		if (tq > 8388607) tq = 8388607;
		if (tq < -8388608) tq = -8388608;
		acc = poly_term(pmid_reg[15:0], 0, 0, p, tq, SUM_SH + 3);
		acc += poly_term(pmid_reg[31:16], 0, 1, p, tq, SUM_SH - 6 - TF);
		acc += poly_term($signed(pmid_reg[39:32]), 0, 2, p, tq, SUM_SH - 8 - 2 * TF);
		acc += poly_term($signed(pmid_reg[47:40]), 0, 3, p, tq, SUM_SH - 15 - 3 * TF);
		acc += poly_term(longint'($signed(plow_reg[15:0])) - 16384, 1, 0, p, tq, SUM_SH - 20);
		acc += poly_term(longint'($signed(plow_reg[31:16])) - 16384, 1, 1, p, tq,
			SUM_SH - 29 - TF);
		acc += poly_term($signed(plow_reg[39:32]), 1, 2, p, tq, SUM_SH - 32 - 2 * TF);
		acc += poly_term($signed(plow_reg[47:40]), 1, 3, p, tq, SUM_SH - 37 - 3 * TF);
		acc += poly_term($signed(phigh_reg[15:0]), 2, 0, p, tq, SUM_SH - 48);
		acc += poly_term($signed(phigh_reg[23:16]), 2, 1, p, tq, SUM_SH - 48 - TF);
		acc += poly_term($signed(phigh_reg[31:24]), 3, 0, p, tq, SUM_SH - 65);
		q = acc >>> (SUM_SH - PF);
		if (acc < 0) press = '0;
		else if (q > 256'sd4194303) press = 64'(OUT_MAX);
		else press = 64'(q[21:0]);
		r.valid = acc > 0;
		if (r.valid) begin
			if (!seeded || rs) begin
				smooth_state = press[21:0];
				seeded = 1'b1;
			end else begin
				a = (alpha_reg > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(alpha_reg);
				s = 64'(smooth_state);
				s = (s * (64'd65536 - a) + press * a) >> 16;
				smooth_state = s[21:0];
			end
		end
		r.temp = tq[23:0];
		r.press = press[21:0];
		r.smooth = smooth_state;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got, want);
		errors++;
	endtask

	// monitor, receiver stalls and watchdog
	always @(posedge clk) begin
		comp_result_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$display("result %0d arrived with nothing pending", n_results);
					errors++;
				end else begin
					e = pending_q.pop_front();
					if (temperature_q16 !== e.temp)
						report_mismatch("temperature_q16", temperature_q16, e.temp);
					if (pressure_sixteenths !== e.press)
						report_mismatch("pressure_sixteenths", pressure_sixteenths, e.press);
					if (smoothed_pressure !== e.smooth)
						report_mismatch("smoothed_pressure", smoothed_pressure, e.smooth);
					if (sample_valid !== e.valid)
						report_mismatch("sample_valid", sample_valid, e.valid);
				end
				if (sample_valid) n_valid++;
				n_results++;
			end
			out_ready <= ($urandom_range(99) >= recv_stall);
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired, nothing transferred for %0d cycles", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			CFG_TEMP: temp_reg = val[39:0];
			CFG_PLOW: plow_reg = val;
			CFG_PMID: pmid_reg = val;
			CFG_PHIGH: phigh_reg = val[31:0];
			CFG_ALPHA: alpha_reg = val[16:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [47:0] tv, input logic [47:0] lv,
		input logic [47:0] mv, input logic [47:0] hv, input logic [47:0] av);
		write_reg(CFG_TEMP, tv);
		write_reg(CFG_PLOW, lv);
		write_reg(CFG_PMID, mv);
		write_reg(CFG_PHIGH, hv);
		write_reg(CFG_ALPHA, av);
		@(posedge clk);
	endtask

	// drop valid so the last item is not sent twice, then wait out the results
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input stim_row_t row);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= row.rp;
		raw_temperature <= row.rt;
		restart_filter <= row.rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		begin
			comp_result_t r;
			r = compensate(row.rp, row.rt, row.rs);
			pending_q.push_back(row.typed ? row.res : r);
		end
		n_items++;
	endtask

	function automatic logic [47:0] rnd48;
		return {16'($urandom), 32'($urandom)};
	endfunction

	// typical calibration: values land well inside the output range
	localparam logic [47:0] TYP_TEMP = 48'({8'hF9, 16'h4A00, 16'h6C00});
	localparam logic [47:0] TYP_PLOW = {8'h02, 8'hFD, 16'd16300, 16'd16484};
	localparam logic [47:0] TYP_PMID = {8'hFE, 8'h05, 16'd30000, 16'd12500};
	localparam logic [47:0] TYP_PHIGH = {16'h0, 8'h03, 8'hFB, 16'd1000};

	stim_row_t table_rows[16];
	stim_row_t row;

	initial begin
		comp_result_t zero_res;
		zero_res = '{temp: '0, press: '0, smooth: '0, valid: 1'b0};
		// under reset calibration every pressure is at or below zero
		table_rows[0] = '{24'h000000, 24'h000000, 1'b0, 1'b1, zero_res};
		table_rows[1] = '{24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, zero_res};
		table_rows[2] = '{24'h800000, 24'h123456, 1'b0, 1'b1, zero_res};
		table_rows[3] = '{24'h000001, 24'h7FFFFF, 1'b1, 1'b1, zero_res};
		table_rows[4] = '{24'h000000, 24'h000000, 1'b0, 1'b0, zero_res};
		table_rows[5] = '{24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, zero_res};
		table_rows[6] = '{24'h000000, 24'hFFFFFF, 1'b0, 1'b0, zero_res};
		table_rows[7] = '{24'hFFFFFF, 24'h000000, 1'b1, 1'b0, zero_res};
		table_rows[8] = '{24'h6B0000, 24'h7F0000, 1'b0, 1'b0, zero_res};
		table_rows[9] = '{24'h6C0000, 24'h800000, 1'b1, 1'b0, zero_res};
		table_rows[10] = '{24'h555555, 24'hAAAAAA, 1'b0, 1'b0, zero_res};
		table_rows[11] = '{24'hAAAAAA, 24'h555555, 1'b0, 1'b0, zero_res};
		table_rows[12] = '{24'h6C0000, 24'h6C0000, 1'b0, 1'b0, zero_res};
		table_rows[13] = '{24'h700000, 24'h700000, 1'b1, 1'b0, zero_res};
		table_rows[14] = '{24'h100000, 24'h900000, 1'b0, 1'b0, zero_res};
		table_rows[15] = '{24'hF00000, 24'h200000, 1'b0, 1'b0, zero_res};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 4; i++) send_item(table_rows[i]);
		drain();
		// an index past the register list must change nothing
		write_reg(CFG_SPARE, rnd48());
		write_all(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PHIGH, 48'd32768);
		for (int i = 4; i < 16; i++) send_item(table_rows[i]);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				0: write_all(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PHIGH, 48'd65536);
				1: write_all(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PHIGH, 48'd0);
				2: write_all('1, '1, '1, '1, 48'h1FFFF);
				3: write_all(rnd48(), rnd48(), rnd48(), rnd48(), 48'($urandom_range(65536)));
				4: write_all('0, '0, '0, '0, 48'd1);
				default: write_all(TYP_TEMP ^ 48'($urandom_range(255)),
					TYP_PLOW, TYP_PMID ^ 48'($urandom_range(4095)), rnd48(),
					48'($urandom_range(131071)));
			endcase
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 84; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 84; end
				default: begin send_idle = 11; recv_stall = 11; end
			endcase
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				row.rp = 24'($urandom);
				row.rt = 24'($urandom);
				row.rs = ($urandom_range(7) == 0);
				row.typed = 1'b0;
				send_item(row);
			end
		end
		in_valid <= 1'b0;
		send_idle = 0;
		recv_stall = 0;
		drain();

		$display("%0d pairs sent under reset, typical, extreme and random calibration,",
			n_items);
		$display("%0d results checked, %0d flagged valid, %0d mismatches", n_results,
			n_valid, errors);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
